>>> hdl/bspline_basis_evaluator_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the B-spline basis evaluator checker.
// ----------------------------------------------------------------------------
`ifndef BSPLINE_BASIS_EVALUATOR_TOP_ASSERT_SVH
`define BSPLINE_BASIS_EVALUATOR_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk and switched off during rst.
`define BSBE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and switched off during rst.
`define BSBE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/bsbe_pkg.sv
// ----------------------------------------------------------------------------
// bsbe_pkg
// Shared constants, codes and types of the B-spline basis evaluator.
// ----------------------------------------------------------------------------
package bsbe_pkg;

  localparam int MAX_KNOTS  = 16;
  localparam int MAX_DEGREE = 5;
  localparam int FRAC_BITS  = 16;

  localparam int IDX_W = $clog2(MAX_KNOTS);
  localparam int VAL_W = 24;
  localparam int Q_BITS = VAL_W - 1;

  localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};
  localparam logic signed [VAL_W-1:0] ONE_VAL =
    ((1 << FRAC_BITS) > ((1 << (VAL_W - 1)) - 1)) ? VAL_MAX : VAL_W'(1 << FRAC_BITS);

  // Input item codes.
  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_EVAL = 1'b1;

  // Configuration register indexes.
  localparam logic CFG_DEGREE = 1'b0;
  localparam logic CFG_KNOTS  = 1'b1;

  // One term request to the divider.
  typedef struct packed {
    logic                     start;
    logic signed [32:0]       num;
    logic signed [VAL_W-1:0]  coef;
    logic [31:0]              span;
  } div_req_t;

endpackage

>>> hdl/bspline_basis_evaluator_top.sv
// A load writes one knot slot and leaves the block ready for the next item. An
// evaluation's pace is set by the bit-serial term divider, which works on one
// term at a time.
// One item at a time; a new item is taken once the last result is registered.
// Reset: synchronous rst sets degree 3 and 8 knots; the knot table is not
// cleared and must be loaded before use.
// ----------------------------------------------------------------------------
// bspline_basis_evaluator_top
// Cox-de Boor B-spline basis evaluator over a knot memory and a basis memory.
// ----------------------------------------------------------------------------
module bspline_basis_evaluator_top import bsbe_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_we,
  input  logic                    cfg_index,
  input  logic [4:0]              cfg_data,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic                    func,
  input  logic [3:0]              knot_slot,
  input  logic signed [31:0]      knot_value,
  input  logic signed [31:0]      x_value,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [3:0]              basis_index,
  output logic signed [VAL_W-1:0] basis_value,
  output logic                    bad_setup,
  output logic                    last
);

  localparam logic [4:0] S_IDLE    = 5'd0;
  localparam logic [4:0] S_BAD     = 5'd1;
  localparam logic [4:0] S_T0      = 5'd2;
  localparam logic [4:0] S_TN      = 5'd3;
  localparam logic [4:0] S_TCHK    = 5'd4;
  localparam logic [4:0] S_SPN_RD  = 5'd5;
  localparam logic [4:0] S_SPN_WR  = 5'd6;
  localparam logic [4:0] S_R0      = 5'd7;
  localparam logic [4:0] S_R1      = 5'd8;
  localparam logic [4:0] S_R2      = 5'd9;
  localparam logic [4:0] S_R3      = 5'd10;
  localparam logic [4:0] S_R4      = 5'd11;
  localparam logic [4:0] S_LEFT    = 5'd12;
  localparam logic [4:0] S_LWAIT   = 5'd13;
  localparam logic [4:0] S_RIGHT   = 5'd14;
  localparam logic [4:0] S_RWAIT   = 5'd15;
  localparam logic [4:0] S_SUM     = 5'd16;
  localparam logic [4:0] S_ZERO    = 5'd17;
  localparam logic [4:0] S_OUT_RD  = 5'd18;
  localparam logic [4:0] S_OUT_LD  = 5'd19;

  logic [4:0] state;
  logic [2:0] spline_degree;
  logic [4:0] knots_in_use;

  logic [IDX_W-1:0] j;
  logic [2:0]       d;
  logic signed [31:0] x_reg, t0, tn, lo, ta, tb, tc, te;
  logic signed [VAL_W-1:0] bj, bj1, left, right;

  // Effective sizes.
  logic [2:0]       p_eff;
  logic [4:0]       n_eff;
  logic signed [6:0] k_s;
  logic [IDX_W-1:0] k_last, cnt_last, cnt_idx, span_last, n_last;

  always_comb begin
    p_eff = (spline_degree == 3'd0) ? 3'd1 :
            (spline_degree > 3'(MAX_DEGREE)) ? 3'(MAX_DEGREE) : spline_degree;
    n_eff = (knots_in_use > 5'(MAX_KNOTS)) ? 5'(MAX_KNOTS) : knots_in_use;
    k_s   = $signed({2'b00, n_eff}) - $signed({4'b0000, p_eff}) - 7'sd1;
    k_last    = IDX_W'(k_s - 7'sd1);
    cnt_idx   = IDX_W'(n_eff - 5'd1 - {2'b00, d});
    cnt_last  = cnt_idx - IDX_W'(1);
    span_last = IDX_W'(n_eff - 5'd2);
    n_last    = IDX_W'(n_eff - 5'd1);
  end

  // Handshakes.
  logic in_xfer, out_free;
  assign in_stall = (state != S_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      spline_degree <= 3'd3;
      knots_in_use  <= 5'd8;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_DEGREE: spline_degree <= cfg_data[2:0];
        CFG_KNOTS:  knots_in_use  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Knot memory.
  logic [IDX_W-1:0] k_raddr;
  logic [31:0]      k_rdata;

  bsbe_ram #(.DEPTH(MAX_KNOTS), .WIDTH(32)) u_knot_ram (
    .clk   (clk),
    .we    (in_xfer && (func == FUNC_LOAD)),
    .waddr (knot_slot),
    .wdata (knot_value),
    .raddr (k_raddr),
    .rdata (k_rdata)
  );

  // Basis value memory.
  logic             b_we;
  logic [IDX_W-1:0] b_waddr, b_raddr;
  logic [VAL_W-1:0] b_wdata, b_rdata;

  bsbe_ram #(.DEPTH(MAX_KNOTS), .WIDTH(VAL_W)) u_basis_ram (
    .clk   (clk),
    .we    (b_we),
    .waddr (b_waddr),
    .wdata (b_wdata),
    .raddr (b_raddr),
    .rdata (b_rdata)
  );

  // Term unit.
  div_req_t                req;
  logic                    div_done;
  logic signed [VAL_W-1:0] div_quot;

  bsbe_div u_div (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .done (div_done),
    .quot (div_quot)
  );

  // Term operands and span tests.
  logic signed [32:0] num_l, span_l, num_r, span_r;
  logic               use_l, use_r;
  logic signed [VAL_W:0] sum_w;
  logic signed [VAL_W-1:0] sum_sat;
  logic below, above, hit, flag;

  always_comb begin
    num_l  = {x_reg[31], x_reg} - {ta[31], ta};
    span_l = {tb[31], tb} - {ta[31], ta};
    num_r  = {te[31], te} - {x_reg[31], x_reg};
    span_r = {te[31], te} - {tc[31], tc};
    use_l  = !span_l[32] && (span_l != '0) && (bj != '0);
    use_r  = !span_r[32] && (span_r != '0) && (bj1 != '0);

    sum_w   = {left[VAL_W-1], left} + {right[VAL_W-1], right};
    sum_sat = (sum_w > $signed({1'b0, VAL_MAX})) ? VAL_MAX :
              (sum_w < $signed({1'b1, VAL_MIN})) ? VAL_MIN : sum_w[VAL_W-1:0];

    below = (x_reg < t0);
    above = (x_reg > tn);
    hit   = (x_reg >= lo) &&
            ((x_reg < $signed(k_rdata)) || ((j == span_last) && (x_reg <= $signed(k_rdata))));
    flag  = below ? (j == '0) : above ? (j == k_last) : hit;
  end

  // Memory addresses, writes and divider requests.
  always_comb begin
    k_raddr = j;
    b_raddr = j;
    b_we    = 1'b0;
    b_waddr = j;
    b_wdata = '0;
    req     = '0;
    case (state)
      S_T0:     k_raddr = '0;
      S_TN:     k_raddr = n_last;
      S_SPN_RD: k_raddr = j + IDX_W'(1);
      S_SPN_WR: begin
        b_we    = 1'b1;
        b_wdata = flag ? ONE_VAL : '0;
      end
      S_R1: begin
        k_raddr = j + IDX_W'(d);
        b_raddr = j + IDX_W'(1);
      end
      S_R2:     k_raddr = j + IDX_W'(1);
      S_R3:     k_raddr = j + IDX_W'(d) + IDX_W'(1);
      S_LEFT: begin
        req.start = use_l;
        req.num   = num_l;
        req.coef  = bj;
        req.span  = span_l[31:0];
      end
      S_RIGHT: begin
        req.start = use_r;
        req.num   = num_r;
        req.coef  = bj1;
        req.span  = span_r[31:0];
      end
      S_SUM: begin
        b_we    = 1'b1;
        b_wdata = sum_sat;
      end
      S_ZERO: begin
        b_we    = 1'b1;
        b_waddr = cnt_idx;
      end
      default: ;
    endcase
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_xfer && (func == FUNC_EVAL)) begin
            state <= (k_s > 7'sd0) ? S_T0 : S_BAD;
          end
        end
        S_BAD:    if (out_free) state <= S_IDLE;
        S_T0:     state <= S_TN;
        S_TN:     state <= S_TCHK;
        S_TCHK:   state <= S_SPN_RD;
        S_SPN_RD: state <= S_SPN_WR;
        S_SPN_WR: state <= (j == span_last) ? S_R0 : S_SPN_RD;
        S_R0:     state <= S_R1;
        S_R1:     state <= S_R2;
        S_R2:     state <= S_R3;
        S_R3:     state <= S_R4;
        S_R4:     state <= S_LEFT;
        S_LEFT:   state <= use_l ? S_LWAIT : S_RIGHT;
        S_LWAIT:  if (div_done) state <= S_RIGHT;
        S_RIGHT:  state <= use_r ? S_RWAIT : S_SUM;
        S_RWAIT:  if (div_done) state <= S_SUM;
        S_SUM:    state <= (j == cnt_last) ? S_ZERO : S_R0;
        S_ZERO:   state <= (d == p_eff) ? S_OUT_RD : S_R0;
        S_OUT_RD: state <= S_OUT_LD;
        S_OUT_LD: begin
          if (out_free) state <= (j == k_last) ? S_IDLE : S_OUT_RD;
        end
        default:  state <= S_IDLE;
      endcase
    end
  end

  // Working registers.
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        x_reg <= x_value;
        j     <= '0;
        d     <= 3'd1;
      end
      S_TN: begin
        t0 <= k_rdata;
        lo <= k_rdata;
      end
      S_TCHK: tn <= k_rdata;
      S_SPN_WR: begin
        lo <= k_rdata;
        j  <= (j == span_last) ? '0 : j + IDX_W'(1);
      end
      S_R1: begin
        ta <= k_rdata;
        bj <= b_rdata;
      end
      S_R2: begin
        tb  <= k_rdata;
        bj1 <= b_rdata;
      end
      S_R3: tc <= k_rdata;
      S_R4: te <= k_rdata;
      S_LEFT: left <= '0;
      S_LWAIT: if (div_done) left <= div_quot;
      S_RIGHT: right <= '0;
      S_RWAIT: if (div_done) right <= div_quot;
      S_SUM: j <= (j == cnt_last) ? j : j + IDX_W'(1);
      S_ZERO: begin
        j <= '0;
        d <= d + 3'd1;
      end
      S_OUT_LD: if (out_free) j <= j + IDX_W'(1);
      default: ;
    endcase
  end

  // Output register; a result waits here until its transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == S_BAD || state == S_OUT_LD) && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_BAD && out_free) begin
      basis_index <= '0;
      basis_value <= '0;
      bad_setup   <= 1'b1;
      last        <= 1'b1;
    end else if (state == S_OUT_LD && out_free) begin
      basis_index <= j;
      basis_value <= b_rdata;
      bad_setup   <= 1'b0;
      last        <= (j == k_last);
    end
  end

endmodule

>>> hdl/bsbe_ram.sv
// ----------------------------------------------------------------------------
// bsbe_ram
// Simple dual-port synchronous RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module bsbe_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

>>> hdl/bsbe_div.sv
// ----------------------------------------------------------------------------
// bsbe_div
// Term unit: multiplies a numerator by a basis value, then divides the
// product by a positive span one quotient bit a cycle, saturating to Q7.16.
// ----------------------------------------------------------------------------
module bsbe_div import bsbe_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  div_req_t                req,
  output logic                    done,
  output logic signed [VAL_W-1:0] quot
);

  localparam logic [2:0] DV_IDLE = 3'd0;
  localparam logic [2:0] DV_MUL  = 3'd1;
  localparam logic [2:0] DV_ABS  = 3'd2;
  localparam logic [2:0] DV_CHK  = 3'd3;
  localparam logic [2:0] DV_ITER = 3'd4;
  localparam logic [2:0] DV_FIN  = 3'd5;

  logic [2:0]              state;
  logic signed [32:0]      num_r;
  logic signed [VAL_W-1:0] coef_r;
  logic [31:0]             span_r;
  logic signed [56:0]      prod;
  logic                    neg;
  logic [55:0]             mag;
  logic [31:0]             rem;
  logic [Q_BITS-1:0]       low;
  logic [Q_BITS-1:0]       q;
  logic [4:0]              cnt;

  logic [56:0] prod_abs;
  logic [32:0] trial;
  logic        ge;

  // Magnitude of the product and one restoring step.
  always_comb begin
    prod_abs = prod[56] ? 57'(-prod) : prod;
    trial    = {rem, low[Q_BITS-1]};
    ge       = (trial >= {1'b0, span_r});
  end

  // Control.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= DV_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        DV_IDLE: if (req.start) state <= DV_MUL;
        DV_MUL:  state <= DV_ABS;
        DV_ABS:  state <= DV_CHK;
        DV_CHK: begin
          if (mag >= {1'b0, span_r, {Q_BITS{1'b0}}}) begin
            done  <= 1'b1;
            state <= DV_IDLE;
          end else begin
            state <= DV_ITER;
          end
        end
        DV_ITER: if (cnt == 5'd1) state <= DV_FIN;
        DV_FIN: begin
          done  <= 1'b1;
          state <= DV_IDLE;
        end
        default: state <= DV_IDLE;
      endcase
    end
  end

  // Datapath.
  always_ff @(posedge clk) begin
    case (state)
      DV_IDLE: begin
        num_r  <= req.num;
        coef_r <= req.coef;
        span_r <= req.span;
        q      <= '0;
      end
      DV_MUL: prod <= num_r * coef_r;
      DV_ABS: begin
        neg <= prod[56];
        mag <= prod_abs[55:0];
      end
      DV_CHK: begin
        quot <= neg ? VAL_MIN : VAL_MAX;
        rem  <= mag[54:Q_BITS];
        low  <= mag[Q_BITS-1:0];
        cnt  <= 5'(Q_BITS);
      end
      DV_ITER: begin
        rem <= ge ? 32'(trial - {1'b0, span_r}) : trial[31:0];
        q   <= {q[Q_BITS-2:0], ge};
        low <= {low[Q_BITS-2:0], 1'b0};
        cnt <= cnt - 5'd1;
      end
      DV_FIN: quot <= neg ? -{1'b0, q} : {1'b0, q};
      default: ;
    endcase
  end

endmodule

>>> hdl/bsbe_checker.sv
// ----------------------------------------------------------------------------
// bsbe_checker
// Port-level checks of the B-spline basis evaluator, bound to the top level.
// ----------------------------------------------------------------------------
`include "bspline_basis_evaluator_top_assert.svh"

module bsbe_checker import bsbe_pkg::*; (
  input logic                    clk,
  input logic                    rst,
  input logic                    cfg_we,
  input logic                    cfg_index,
  input logic [4:0]              cfg_data,
  input logic                    in_valid,
  input logic                    in_stall,
  input logic                    func,
  input logic [3:0]              knot_slot,
  input logic signed [31:0]      knot_value,
  input logic signed [31:0]      x_value,
  input logic                    out_valid,
  input logic                    out_stall,
  input logic [3:0]              basis_index,
  input logic signed [VAL_W-1:0] basis_value,
  input logic                    bad_setup,
  input logic                    last
);

  // A stalled result stays on the port unchanged.
  `BSBE_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(basis_value) && $stable(basis_index) && $stable(last), "stalled result changed")

  // The error result is a lone, empty, final result.
  `BSBE_ASSERT_NOW(a_bad_form, out_valid && bad_setup, last && (basis_index == 4'd0) && (basis_value == '0), "malformed error result")

  // An evaluation occupies the block in the cycle after its transfer.
  `BSBE_ASSERT_NEXT(a_eval_busy, in_valid && !in_stall && (func == FUNC_EVAL), in_stall, "evaluation did not hold the input")

  // A knot load leaves the input free in the cycle after its transfer.
  `BSBE_ASSERT_NEXT(a_load_free, in_valid && !in_stall && (func == FUNC_LOAD), !in_stall, "knot load held the input")

endmodule

bind bspline_basis_evaluator_top bsbe_checker u_bsbe_checker (.*);
